[design/bsa_pkg.sv]
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

   localparam int MaxSlots      = 1024;
   localparam int WordBits      = 64;
   localparam int AddrBits      = 48;
   localparam int MaxObjectSize = 32768;
   localparam int NumWords      = MaxSlots / WordBits;
   localparam int WordIdxBits   = $clog2(NumWords);
   localparam int BitIdxBits    = $clog2(WordBits);
   localparam int SlotBits      = $clog2(MaxSlots);
   localparam int CountBits     = SlotBits + 1;
   localparam int SizeBits      = 16;

   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   localparam logic [1:0] ACT_INIT   = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_RANGE  = 3'd2;
   localparam logic [2:0] ST_ALIGN  = 3'd3;
   localparam logic [2:0] ST_DOUBLE = 3'd4;

   localparam logic [1:0] CSR_OBJECT_SIZE   = 2'd0;
   localparam logic [1:0] CSR_SLOT_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_DATA_BASE     = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [AddrBits-1:0] address;
   } req_word_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [SlotBits-1:0]  slot;
      logic [AddrBits-1:0]  object_address;
      logic [CountBits-1:0] in_use;
   } rsp_word_type;

endpackage

[design/bitmap_slot_allocator_top.sv]
// Bitmap slot allocator: free bitmap in one synchronous memory, sequenced per word.
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  req_word_type (action, address)
//   rsp      out        rsp_valid / rsp_stall  rsp_word_type (status, slot, addr, in_use)
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One word at a time. Initialize writes one bitmap word per cycle.
// Allocate reads each scanned bitmap word, then tests it, then clears the
// bit, multiplies and adds; a full count answers without a scan, and a scan
// that finds nothing answers full. Free and lookup run a restoring divider at
// one quotient bit per cycle. An address below the base answers without
// dividing, a lookup beyond the span right after the span check.
// Reset is synchronous; it clears the per-word valid bits, so every bitmap word
// reads as zero until initialize writes it. No clearing pass is needed.
// The result sits in an output register; a stalled result holds there while
// the next request is accepted and worked on.
module bitmap_slot_allocator_top
   import bsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_word_type        req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_word_type        rsp_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [AddrBits-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_AREAD, S_AWAIT, S_AFIND, S_AMUL, S_AADD,
      S_LSPAN, S_LCHK, S_DIV, S_DCHK, S_FWAIT, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [SizeBits-1:0]  size_cfg_ff;
   logic [10:0]          cap_cfg_ff;
   logic [AddrBits-1:0]  base_cfg_ff;

   // allocator state outside the memory
   logic [CountBits-1:0]   used_ff;
   logic [WordIdxBits:0]   search_ff;

   // per-item work registers
   logic [1:0]             act_ff;
   logic [AddrBits-1:0]    off_ff;
   logic [AddrBits-1:0]    quo_ff;
   logic [SizeBits-1:0]    rem_ff;
   logic [5:0]             cnt_ff;
   logic [WordIdxBits:0]   scan_ff;
   logic [WordBits-1:0]    word_ff;
   logic [SlotBits-1:0]    slot_ff;
   logic [26:0]            prod_ff;
   logic [2:0]             status_ff;
   logic [AddrBits-1:0]    oaddr_ff;

   // output register
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;

   // bitmap memory, one read and one write port
   logic [WordBits-1:0]    map_mem [NumWords];
   logic [NumWords-1:0]    map_vld_ff;
   logic [WordBits-1:0]    rd_ff;
   logic                   rd_vld_ff;
   logic                   mem_we;
   logic [WordIdxBits-1:0] mem_waddr;
   logic [WordBits-1:0]    mem_wdata;
   logic [WordIdxBits-1:0] mem_raddr;

   logic [SizeBits-1:0]    eff_size;
   logic [CountBits-1:0]   eff_cap;
   logic [WordIdxBits:0]   words_used;
   logic [WordIdxBits:0]   full_words;
   logic [BitIdxBits-1:0]  part_bits;
   logic [WordBits-1:0]    init_word;
   logic [WordBits-1:0]    rd_word;
   logic [WordBits-1:0]    low_onehot;
   logic [BitIdxBits-1:0]  low_idx;
   logic [WordBits-1:0]    word_left;
   logic [SizeBits:0]      rem_sh;
   logic                   rem_ge;
   logic [WordBits-1:0]    free_mask;
   logic [AddrBits-1:0]    req_off;
   logic                   done_go;

   // effective size and capacity after saturation
   always_comb begin
      if (size_cfg_ff == '0) begin
         eff_size = SizeBits'(1);
      end else if (32'(size_cfg_ff) > MaxObjectSize) begin
         eff_size = SizeBits'(MaxObjectSize);
      end else begin
         eff_size = size_cfg_ff;
      end
      if (32'(cap_cfg_ff) > MaxSlots) begin
         eff_cap = CountBits'(MaxSlots);
      end else begin
         eff_cap = CountBits'(cap_cfg_ff);
      end
   end

   assign words_used = (WordIdxBits+1)'((12'(eff_cap) + 12'(WordBits - 1)) >> BitIdxBits);
   assign full_words = (WordIdxBits+1)'(eff_cap >> BitIdxBits);
   assign part_bits  = eff_cap[BitIdxBits-1:0];
   assign req_off    = req_word.address - base_cfg_ff;

   always_comb begin
      if ((WordIdxBits+1)'(scan_ff[WordIdxBits-1:0]) < full_words) begin
         init_word = '1;
      end else if ((WordIdxBits+1)'(scan_ff[WordIdxBits-1:0]) == full_words
                   && part_bits != '0) begin
         init_word = ~({WordBits{1'b1}} << part_bits);
      end else begin
         init_word = '0;
      end
   end

   // words never written read as all-zero (no slot free)
   assign rd_word    = rd_vld_ff ? rd_ff : '0;
   assign low_onehot = word_ff & (~word_ff + WordBits'(1));
   assign word_left  = word_ff & ~low_onehot;

   always_comb begin
      low_idx = '0;
      for (int j = 0; j < WordBits; j++) begin
         if (low_onehot[j]) begin
            low_idx = low_idx | BitIdxBits'(j);
         end
      end
   end

   // one restoring-division step
   assign rem_sh = {rem_ff, quo_ff[AddrBits-1]};
   assign rem_ge = rem_sh >= (SizeBits+1)'(eff_size);

   assign free_mask = WordBits'(1) << quo_ff[BitIdxBits-1:0];

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = scan_ff[WordIdxBits-1:0];
      mem_wdata = init_word;
      mem_raddr = scan_ff[WordIdxBits-1:0];
      unique case (state_ff)
         S_INIT: begin
            mem_we = 1'b1;
         end
         S_AFIND: begin
            mem_we    = 1'b1;
            mem_wdata = word_left;
         end
         S_DCHK: begin
            mem_raddr = quo_ff[SlotBits-1:BitIdxBits];
         end
         S_FWAIT: begin
            mem_waddr = quo_ff[SlotBits-1:BitIdxBits];
            mem_wdata = rd_word | free_mask;
            mem_we    = act_ff == ACT_FREE && (rd_word & free_mask) == '0
                        && used_ff != '0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_we) begin
            map_vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= map_vld_ff[mem_raddr];
      end
   end

   // configuration writes; index three is not a register and is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_cfg_ff <= SizeBits'(8);
         cap_cfg_ff  <= '0;
         base_cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OBJECT_SIZE:   size_cfg_ff <= csr_wdata[SizeBits-1:0];
            CSR_SLOT_CAPACITY: cap_cfg_ff  <= csr_wdata[10:0];
            CSR_DATA_BASE:     base_cfg_ff <= csr_wdata;
            default:           size_cfg_ff <= size_cfg_ff;
         endcase
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign done_go   = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         search_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise valid when a finished word moves in, drop it once taken
         if (state_ff == S_DONE && done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  act_ff    <= req_word.action;
                  status_ff <= ST_OK;
                  slot_ff   <= '0;
                  oaddr_ff  <= '0;
                  off_ff    <= req_off;
                  quo_ff    <= req_off;
                  rem_ff    <= '0;
                  cnt_ff    <= '0;
                  unique case (req_word.action)
                     ACT_INIT: begin
                        scan_ff  <= '0;
                        state_ff <= S_INIT;
                     end
                     ACT_ALLOC: begin
                        scan_ff <= search_ff;
                        if (used_ff >= eff_cap) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_AREAD;
                        end
                     end
                     ACT_FREE: begin
                        if (req_word.address < base_cfg_ff) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_DIV;
                        end
                     end
                     default: begin
                        if (req_word.address < base_cfg_ff) begin
                           status_ff <= ST_RANGE;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_LSPAN;
                        end
                     end
                  endcase
               end
            end
            S_INIT: begin
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff[WordIdxBits-1:0] == WordIdxBits'(NumWords - 1)) begin
                  used_ff   <= '0;
                  search_ff <= '0;
                  state_ff  <= S_DONE;
               end
            end
            S_AREAD: begin
               if (scan_ff >= words_used) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_AWAIT;
               end
            end
            S_AWAIT: begin
               word_ff <= rd_word;
               if (rd_word == '0) begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_AREAD;
               end else begin
                  state_ff <= S_AFIND;
               end
            end
            S_AFIND: begin
               used_ff   <= used_ff + 1'b1;
               search_ff <= (word_left == '0) ? scan_ff + 1'b1 : scan_ff;
               slot_ff   <= {scan_ff[WordIdxBits-1:0], low_idx};
               state_ff  <= S_AMUL;
            end
            S_AMUL: begin
               prod_ff  <= 27'(slot_ff) * 27'(eff_size);
               state_ff <= S_AADD;
            end
            S_AADD: begin
               oaddr_ff <= base_cfg_ff + AddrBits'(prod_ff);
               state_ff <= S_DONE;
            end
            S_LSPAN: begin
               prod_ff  <= 27'(eff_cap) * 27'(eff_size);
               state_ff <= S_LCHK;
            end
            S_LCHK: begin
               if (off_ff >= AddrBits'(prod_ff)) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_ge ? SizeBits'(rem_sh - (SizeBits+1)'(eff_size))
                                : rem_sh[SizeBits-1:0];
               quo_ff <= {quo_ff[AddrBits-2:0], rem_ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 6'(AddrBits - 1)) begin
                  state_ff <= S_DCHK;
               end
            end
            S_DCHK: begin
               if (rem_ff != '0) begin
                  status_ff <= ST_ALIGN;
                  state_ff  <= S_DONE;
               end else if (act_ff == ACT_LOOKUP) begin
                  slot_ff  <= quo_ff[SlotBits-1:0];
                  state_ff <= S_DONE;
               end else if (quo_ff >= AddrBits'(eff_cap)) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_FWAIT;
               end
            end
            S_FWAIT: begin
               if ((rd_word & free_mask) != '0 || used_ff == '0) begin
                  status_ff <= ST_DOUBLE;
               end else begin
                  used_ff <= used_ff - 1'b1;
                  slot_ff <= quo_ff[SlotBits-1:0];
                  if ((WordIdxBits+1)'(quo_ff[SlotBits-1:BitIdxBits]) < search_ff) begin
                     search_ff <= (WordIdxBits+1)'(quo_ff[SlotBits-1:BitIdxBits]);
                  end
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // hold until the output register is free, then hand over
               if (done_go) begin
                  rsp_word_ff.status         <= status_ff;
                  rsp_word_ff.slot           <= slot_ff;
                  rsp_word_ff.object_address <= oaddr_ff;
                  rsp_word_ff.in_use         <= used_ff;
                  state_ff                   <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[design/bsa_checker.sv]
// Port-level checker for the bitmap slot allocator, bound to the top level.
module bsa_checker
   import bsa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rsp_word_type        rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.slot == '0)
      else $error("failed action reports a slot");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.object_address == '0)
      else $error("failed action reports an object address");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_word.in_use) <= MaxSlots)
      else $error("in-use count beyond slot limit");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (.*);

[bench/tb_bitmap_slot_allocator_top.sv]
// Self-checking bench for the bitmap slot allocator: directed table, then randomized traffic.
module tb_bitmap_slot_allocator_top;
   import bsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 200000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_word_type        req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = CSR_OBJECT_SIZE;
   logic [AddrBits-1:0] csr_wdata = '0;

   bitmap_slot_allocator_top u_top (.*);

   always #10 clock = ~clock;

   // Mirror of the allocator: bitmap, count, cursor and registers.
   logic [WordBits-1:0] mirror_map [NumWords];
   int unsigned         mirror_used;
   int unsigned         mirror_cursor;
   logic [15:0]         reg_size;
   logic [10:0]         reg_cap;
   logic [AddrBits-1:0] reg_base;

   rsp_word_type expected_q[$];
   int  mismatches = 0;
   int  accepted_rsp = 0;
   int  sent_req = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_rsp = 1'b0;
   bit  timed_out = 1'b0;
   // Live allocations, used to aim frees and lookups at real objects.
   logic [AddrBits-1:0] live_addr[$];

   function automatic rsp_word_type predict_action(req_word_type w);
      rsp_word_type r;
      longint unsigned size, off, span;
      int unsigned cap, nw, idx, wi;
      bit found;
      r = '0;
      size = (reg_size == 0) ? 64'd1 :
             (reg_size > MaxObjectSize ? 64'(MaxObjectSize) : 64'(reg_size));
      cap = (reg_cap > MaxSlots) ? MaxSlots : 32'(reg_cap);
      nw = (cap + WordBits - 1) / WordBits;
      r.status = ST_OK;
      case (w.action)
         ACT_INIT: begin
            for (int i = 0; i < NumWords; i++) begin
               if (i < cap / WordBits) mirror_map[i] = '1;
               else if (i == cap / WordBits && cap % WordBits != 0)
                  mirror_map[i] = (64'd1 << (cap % WordBits)) - 64'd1;
               else mirror_map[i] = '0;
            end
            mirror_used = 0;
            mirror_cursor = 0;
         end
         ACT_ALLOC: begin
            found = 1'b0;
            if (mirror_used < cap) begin
               for (int i = mirror_cursor; i < nw && i < NumWords && !found; i++) begin
                  if (mirror_map[i] != 0) begin
                     int b;
                     b = 0;
                     while (b < WordBits - 1 && !mirror_map[i][b]) b++;
                     mirror_map[i][b] = 1'b0;
                     mirror_used++;
                     mirror_cursor = (mirror_map[i] == 0) ? i + 1 : i;
                     r.slot = SlotBits'(i * WordBits + b);
                     r.object_address =
                        AddrBits'(64'(reg_base) + 64'(i * WordBits + b) * size);
                     found = 1'b1;
                  end
               end
            end
            if (!found) r.status = ST_FULL;
         end
         ACT_FREE: begin
            if (w.address < reg_base) r.status = ST_RANGE;
            else begin
               off = 64'(w.address - reg_base);
               if (off % size != 0) r.status = ST_ALIGN;
               else if (off / size >= cap) r.status = ST_RANGE;
               else begin
                  idx = 32'(off / size);
                  wi = idx / WordBits;
                  if (mirror_map[wi][idx % WordBits] || mirror_used == 0)
                     r.status = ST_DOUBLE;
                  else begin
                     mirror_map[wi][idx % WordBits] = 1'b1;
                     mirror_used--;
                     if (wi < mirror_cursor) mirror_cursor = wi;
                     r.slot = SlotBits'(idx);
                  end
               end
            end
         end
         default: begin
            span = longint'(cap) * size;
            if (w.address < reg_base || w.address - reg_base >= span) r.status = ST_RANGE;
            else if ((w.address - reg_base) % size != 0) r.status = ST_ALIGN;
            else r.slot = SlotBits'((w.address - reg_base) / size);
         end
      endcase
      r.in_use = CountBits'(mirror_used);
      return r;
   endfunction

   // Accept results and compare each against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         accepted_rsp <= accepted_rsp + 1;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_word);
         end else begin
            rsp_word_type e;
            e = expected_q.pop_front();
            if (e.status != rsp_word.status || e.slot != rsp_word.slot ||
                e.object_address != rsp_word.object_address ||
                e.in_use != rsp_word.in_use) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", e, rsp_word);
            end
         end
      end
   end

   // Drive the receiver's stall; a long hold-off overrides the random pattern.
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
   end

   // Watchdog: count cycles in which nothing is accepted on any channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         timed_out = 1'b1;
         $display("Watchdog expired with %0d results still expected", expected_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Write one register while the block is idle; keep the mirror in step.
   task automatic write_reg(logic [1:0] index, logic [AddrBits-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_OBJECT_SIZE:   reg_size = value[15:0];
         CSR_SLOT_CAPACITY: reg_cap = value[10:0];
         default:           reg_base = value;
      endcase
   endtask

   // Offer one word, with random gaps ahead of it; predict it when it is taken.
   task automatic send_word(logic [1:0] action, logic [AddrBits-1:0] address);
      req_word_type w;
      rsp_word_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      w.action = action;
      w.address = address;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      r = predict_action(w);
      if (action == ACT_ALLOC && r.status == ST_OK) live_addr.push_back(r.object_address);
      if (action == ACT_INIT) live_addr.delete();
      expected_q.push_back(r);
      sent_req++;
   endtask

   // Drop valid and wait until every expected result has come, plus settle time.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Well-formed traffic with random content: mostly alloc/free of live objects.
   task automatic random_burst(int count);
      int pick, k;
      logic [AddrBits-1:0] a;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) send_word(ACT_ALLOC, '0);
         else if (pick < 70 && live_addr.size() != 0) begin
            k = $urandom_range(live_addr.size() - 1);
            a = live_addr[k];
            live_addr.delete(k);
            send_word(ACT_FREE, a);
         end else if (pick < 82 && live_addr.size() != 0)
            send_word(ACT_LOOKUP, live_addr[$urandom_range(live_addr.size() - 1)]);
         else if (pick < 90)
            send_word(pick[0] ? ACT_FREE : ACT_LOOKUP,
                      AddrBits'(reg_base + $urandom_range(reg_cap + 4) * reg_size
                                + $urandom_range(2)));
         else if (pick < 97)
            send_word(($urandom_range(1) != 0) ? ACT_FREE : ACT_LOOKUP,
                      AddrBits'({$urandom, $urandom}));
         else send_word(ACT_INIT, AddrBits'({$urandom, $urandom}));
      end
   endtask

   typedef struct {
      logic [1:0]          action;
      logic [AddrBits-1:0] address;
      bit                  known;
      rsp_word_type        result;
   } directed_row_type;

   directed_row_type directed_table[] = '{
      // Nothing configured: alloc is full, free and lookup out of range.
      '{ACT_ALLOC,  48'h0,              1'b1, '{ST_FULL,  10'd0, 48'h0, 11'd0}},
      '{ACT_FREE,   48'h0,              1'b1, '{ST_RANGE, 10'd0, 48'h0, 11'd0}},
      '{ACT_LOOKUP, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_RANGE, 10'd0, 48'h0, 11'd0}},
      '{ACT_INIT,   48'hFFFF_FFFF_FFFF, 1'b1, '{ST_OK,    10'd0, 48'h0, 11'd0}},
      '{ACT_ALLOC,  48'h0,              1'b1, '{ST_FULL,  10'd0, 48'h0, 11'd0}}
   };

   directed_row_type after_cfg_table[] = '{
      // Capacity 3, size 16, base 0x100 after init.
      '{ACT_INIT,   48'h0,   1'b1, '{ST_OK,     10'd0, 48'h0,   11'd0}},
      '{ACT_FREE,   48'h100, 1'b1, '{ST_DOUBLE, 10'd0, 48'h0,   11'd0}},
      '{ACT_ALLOC,  48'h0,   1'b1, '{ST_OK,     10'd0, 48'h100, 11'd1}},
      '{ACT_ALLOC,  48'h0,   1'b1, '{ST_OK,     10'd1, 48'h110, 11'd2}},
      '{ACT_ALLOC,  48'h0,   1'b1, '{ST_OK,     10'd2, 48'h120, 11'd3}},
      '{ACT_ALLOC,  48'h0,   1'b1, '{ST_FULL,   10'd0, 48'h0,   11'd3}},
      '{ACT_FREE,   48'hFF,  1'b1, '{ST_RANGE,  10'd0, 48'h0,   11'd3}},
      '{ACT_FREE,   48'h108, 1'b1, '{ST_ALIGN,  10'd0, 48'h0,   11'd3}},
      '{ACT_FREE,   48'h130, 1'b1, '{ST_RANGE,  10'd0, 48'h0,   11'd3}},
      '{ACT_FREE,   48'h110, 1'b1, '{ST_OK,     10'd1, 48'h0,   11'd2}},
      '{ACT_FREE,   48'h110, 1'b1, '{ST_DOUBLE, 10'd0, 48'h0,   11'd2}},
      '{ACT_LOOKUP, 48'h120, 1'b1, '{ST_OK,     10'd2, 48'h0,   11'd2}},
      '{ACT_LOOKUP, 48'h130, 1'b1, '{ST_RANGE,  10'd0, 48'h0,   11'd2}},
      '{ACT_LOOKUP, 48'h121, 1'b1, '{ST_ALIGN,  10'd0, 48'h0,   11'd2}},
      '{ACT_ALLOC,  48'h0,   1'b0, '{ST_OK,     10'd0, 48'h0,   11'd0}}
   };

   // Walk a table; rows with a typed result are checked against it too.
   task automatic run_table(directed_row_type rows[]);
      rsp_word_type r;
      foreach (rows[i]) begin
         send_word(rows[i].action, rows[i].address);
         r = expected_q[$];
         if (rows[i].known && r != rows[i].result) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d: expected %p, predicted %p", i, rows[i].result, r);
         end
      end
      drain();
   endtask

   // One phase: set size, capacity and base, initialize, then run random traffic.
   task automatic phase(logic [15:0] size, logic [10:0] cap, logic [AddrBits-1:0] base,
                        int count, int idle, int stall);
      drain();
      write_reg(CSR_OBJECT_SIZE, AddrBits'(size));
      write_reg(CSR_SLOT_CAPACITY, AddrBits'(cap));
      write_reg(CSR_DATA_BASE, base);
      send_idle_pct = idle;
      stall_pct = stall;
      send_word(ACT_INIT, '0);
      random_burst(count);
   endtask

   initial begin
      for (int i = 0; i < NumWords; i++) mirror_map[i] = '0;
      mirror_used = 0;
      mirror_cursor = 0;
      reg_size = 8;
      reg_cap = 0;
      reg_base = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_table(directed_table);
      write_reg(CSR_OBJECT_SIZE, 48'd16);
      write_reg(CSR_SLOT_CAPACITY, 48'd3);
      write_reg(CSR_DATA_BASE, 48'h100);
      run_table(after_cfg_table);

      phase(16'd0,     11'd130,  48'h0,              120, 0,  0);
      phase(16'hFFFF,  11'd2047, 48'hFFFF_FFFF_0000, 250, 77, 0);
      phase(16'd24,    11'd1024, AddrBits'({$urandom, $urandom}), 250, 0, 77);
      phase(16'd1,     11'd64,   48'h0,              150, 11, 11);
      phase(16'd37,    11'd200,  48'h1234,           150, 0,  0);

      // Hold the receiver off long enough that the block backs up its input.
      send_idle_pct = 0;
      stall_pct = 0;
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         random_burst(40);
      join
      drain();

      // Capacity shrinks without re-initialization.
      write_reg(CSR_SLOT_CAPACITY, 48'd70);
      random_burst(60);
      drain();
      write_reg(CSR_SLOT_CAPACITY, 48'd0);
      random_burst(20);

      phase(16'd32768, 11'd512, 48'h8000, 380, 30, 30);
      drain();

      $display("Ran %0d requests and checked %0d results across several register settings",
               sent_req, accepted_rsp);
      if (mismatches == 0 && expected_q.size() == 0 && !timed_out) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
